/* rtl/core/serpentine_led_framebuffer_defines.svh */
// assertion helpers shared by the framebuffer rtl
`ifndef SERPENTINE_LED_FRAMEBUFFER_DEFINES_SVH
`define SERPENTINE_LED_FRAMEBUFFER_DEFINES_SVH

// property checked on every edge outside reset
`define SLED_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// condition now implies consequence on the next edge
`define SLED_ASSERT_NEXT(name, cond, conseq, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

/* rtl/core/sled_pkg.sv */
package sled_pkg;

    // widest store address over the supported matrix sizes (64 x 64)
    localparam int ADDR_W      = 12;

    // command queue between classifier and executor
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // input kinds
    localparam logic [2:0] KIND_PAINT      = 3'd0;
    localparam logic [2:0] KIND_SCROLL     = 3'd1;
    localparam logic [2:0] KIND_FILL_COLOR = 3'd2;
    localparam logic [2:0] KIND_FILL_BLACK = 3'd3;
    localparam logic [2:0] KIND_FETCH      = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_RED   = 2'd0;
    localparam logic [1:0] CFG_GREEN = 2'd1;
    localparam logic [1:0] CFG_BLUE  = 2'd2;

    typedef enum logic [1:0] {
        CMD_PAINT,
        CMD_SCROLL,
        CMD_FILL,
        CMD_FETCH
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FILL,
        BK_SCROLL,
        BK_FETCH
    } bk_state_t;

    typedef struct packed {
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        cmd_t              cmd;
        logic              zero;
        logic [ADDR_W-1:0] addr;
    } q_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic clearing;
    } bk_status_t;

endpackage

/* rtl/core/sled_front.sv */
module sled_front
    import sled_pkg::*;
#(
    parameter int MATRIX_WIDTH  = 16,
    parameter int MATRIX_HEIGHT = 16
)
(
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] kind,
    input  logic [3:0] x_coord,
    input  logic [3:0] y_coord,
    input  logic [7:0] chain_index,
    input  q_status_t  q_status,
    input  bk_status_t bk_status,
    output logic       push,
    output q_item_t    push_item
);

    localparam int PIXEL_COUNT = MATRIX_WIDTH * MATRIX_HEIGHT;

    logic [15:0] x_w;
    logic [15:0] y_w;
    logic [15:0] row_w;
    logic [15:0] col_w;
    logic [15:0] addr_w;
    logic        useful;

    // serpentine mapping: flipped row, odd rows reversed
    assign x_w    = 16'(x_coord);
    assign y_w    = 16'(y_coord);
    assign row_w  = 16'(MATRIX_HEIGHT - 1) - y_w;
    assign col_w  = row_w[0] ? (16'(MATRIX_WIDTH - 1) - x_w) : x_w;
    assign addr_w = 16'(MATRIX_WIDTH) * row_w + col_w;

    assign in_ready = !q_status.full && !bk_status.clearing;

    always_comb
    begin
        useful         = 1'b0;
        push_item.cmd  = CMD_PAINT;
        push_item.zero = 1'b0;
        push_item.addr = '0;
        unique case (kind) inside
            KIND_PAINT:
            begin
                // off-matrix paint leaves the store alone
                useful         = (x_w < 16'(MATRIX_WIDTH)) && (y_w < 16'(MATRIX_HEIGHT));
                push_item.cmd  = CMD_PAINT;
                push_item.addr = addr_w[ADDR_W-1:0];
            end
            KIND_SCROLL:
            begin
                useful        = 1'b1;
                push_item.cmd = CMD_SCROLL;
            end
            KIND_FILL_COLOR, KIND_FILL_BLACK:
            begin
                useful         = 1'b1;
                push_item.cmd  = CMD_FILL;
                push_item.zero = (kind == KIND_FILL_BLACK);
            end
            KIND_FETCH:
            begin
                // fetch past the chain end reads black
                useful         = 1'b1;
                push_item.cmd  = CMD_FETCH;
                push_item.zero = (16'(chain_index) >= 16'(PIXEL_COUNT));
                push_item.addr = ADDR_W'(chain_index);
            end
            default:
            begin
                useful = 1'b0;
            end
        endcase
    end

    assign push = in_valid && in_ready && useful;

endmodule

/* rtl/core/sled_queue.sv */
`include "serpentine_led_framebuffer_defines.svh"

module sled_queue
    import sled_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  q_item_t   push_item,
    input  logic      pop,
    output q_item_t   head_item,
    output q_status_t q_status
);

    q_item_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head_item      = entry_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);

    `SLED_ASSERT(a_q_no_overflow, push |-> !q_status.full, "push into full queue")
    `SLED_ASSERT(a_q_no_underflow, pop |-> !q_status.empty, "pop from empty queue")
    `SLED_ASSERT_NEXT(a_q_count_up, push && !pop, count_reg == $past(count_reg) + QCNT_W'(1), "queue count lost a push")

endmodule

/* rtl/core/sled_back.sv */
`include "serpentine_led_framebuffer_defines.svh"

module sled_back
    import sled_pkg::*;
#(
    parameter int MATRIX_WIDTH  = 16,
    parameter int MATRIX_HEIGHT = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_item_t    head_item,
    input  q_status_t  q_status,
    output logic       pop,
    input  pixel_t     color,
    output logic       out_valid,
    input  logic       out_ready,
    output pixel_t     out_pixel,
    output bk_status_t bk_status
);

    localparam int PIXEL_COUNT = MATRIX_WIDTH * MATRIX_HEIGHT;
    localparam int AW          = $clog2(PIXEL_COUNT);
    localparam int CW          = $clog2(MATRIX_WIDTH + 1);
    localparam int RW          = $clog2(MATRIX_HEIGHT);

    pixel_t    pixel_store [PIXEL_COUNT];
    pixel_t    rd_data_reg;

    bk_state_t state_reg;
    bk_state_t state_next;
    logic [AW-1:0] sweep_reg;
    logic [AW-1:0] sweep_next;
    pixel_t        fill_value_reg;
    pixel_t        fill_value_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic [CW-1:0] step_reg;
    logic [CW-1:0] step_next;
    logic [AW-1:0] base_reg;
    logic [AW-1:0] base_next;
    logic          fetch_zero_reg;
    logic          fetch_zero_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    pixel_t        out_data_reg;
    pixel_t        out_data_next;
    logic          clearing_reg;
    logic          clearing_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    pixel_t        wr_data;
    logic [AW-1:0] rd_addr;
    logic          out_free;
    logic          sweep_last;
    logic          row_end;
    logic          scroll_last;
    logic [AW-1:0] scroll_rd_addr;
    logic [AW-1:0] scroll_wr_addr;

    function automatic logic [AW-1:0] col_addr(
        input logic [AW-1:0] base,
        input logic          odd,
        input logic [CW-1:0] col
    );
        return odd ? base + AW'(CW'(MATRIX_WIDTH - 1) - col) : base + AW'(col);
    endfunction

    assign out_free       = !out_valid_reg || out_ready;
    assign sweep_last     = (sweep_reg == AW'(PIXEL_COUNT - 1));
    assign row_end        = (step_reg == CW'(MATRIX_WIDTH));
    assign scroll_last    = row_end && (row_reg == RW'(MATRIX_HEIGHT - 1));
    // read one column ahead of the write
    assign scroll_rd_addr = col_addr(base_reg, row_reg[0], step_reg + CW'(1));
    assign scroll_wr_addr = col_addr(base_reg, row_reg[0], step_reg - CW'(1));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pixel_store[wr_addr] <= wr_data;
        end
        rd_data_reg <= pixel_store[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    unique case (head_item.cmd)
                        CMD_PAINT:  state_next = BK_IDLE;
                        CMD_SCROLL: state_next = BK_SCROLL;
                        CMD_FILL:   state_next = BK_FILL;
                        CMD_FETCH:  state_next = out_free ? BK_FETCH : BK_IDLE;
                    endcase
                end
            end
            BK_FILL:
            begin
                if (sweep_last)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_SCROLL:
            begin
                if (scroll_last)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_FETCH:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop             = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = sweep_reg;
        wr_data         = fill_value_reg;
        rd_addr         = head_item.addr[AW-1:0];
        sweep_next      = sweep_reg;
        fill_value_next = fill_value_reg;
        row_next        = row_reg;
        step_next       = step_reg;
        base_next       = base_reg;
        fetch_zero_next = fetch_zero_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        clearing_next   = clearing_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    unique case (head_item.cmd)
                        CMD_PAINT:
                        begin
                            pop     = 1'b1;
                            wr_en   = 1'b1;
                            wr_addr = head_item.addr[AW-1:0];
                            wr_data = color;
                        end
                        CMD_SCROLL:
                        begin
                            pop       = 1'b1;
                            row_next  = '0;
                            step_next = '0;
                            base_next = '0;
                        end
                        CMD_FILL:
                        begin
                            pop             = 1'b1;
                            sweep_next      = '0;
                            fill_value_next = head_item.zero ? pixel_t'('0) : color;
                        end
                        CMD_FETCH:
                        begin
                            if (out_free)
                            begin
                                pop             = 1'b1;
                                fetch_zero_next = head_item.zero;
                            end
                        end
                    endcase
                end
            end
            BK_FILL:
            begin
                wr_en      = 1'b1;
                sweep_next = sweep_reg + AW'(1);
                if (sweep_last)
                begin
                    clearing_next = 1'b0;
                end
            end
            BK_SCROLL:
            begin
                rd_addr = scroll_rd_addr;
                if (step_reg != '0)
                begin
                    wr_en   = 1'b1;
                    wr_addr = scroll_wr_addr;
                    wr_data = row_end ? pixel_t'('0) : rd_data_reg;
                end
                if (row_end)
                begin
                    step_next = '0;
                    row_next  = row_reg + RW'(1);
                    base_next = base_reg + AW'(MATRIX_WIDTH);
                end
                else
                begin
                    step_next = step_reg + CW'(1);
                end
            end
            BK_FETCH:
            begin
                out_valid_next = 1'b1;
                out_data_next  = fetch_zero_reg ? pixel_t'('0) : rd_data_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // reset starts a black fill of the whole store
            state_reg      <= BK_FILL;
            sweep_reg      <= '0;
            fill_value_reg <= '0;
            row_reg        <= '0;
            step_reg       <= '0;
            base_reg       <= '0;
            fetch_zero_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            clearing_reg   <= 1'b1;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_reg      <= sweep_next;
            fill_value_reg <= fill_value_next;
            row_reg        <= row_next;
            step_reg       <= step_next;
            base_reg       <= base_next;
            fetch_zero_reg <= fetch_zero_next;
            out_valid_reg  <= out_valid_next;
            clearing_reg   <= clearing_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid          = out_valid_reg;
    assign out_pixel          = out_data_reg;
    assign bk_status.clearing = clearing_reg;

    `SLED_ASSERT(a_bk_fetch_out_free, (state_reg == BK_FETCH) |-> !out_valid_reg, "fetch would overwrite a waiting result")
    `SLED_ASSERT(a_bk_clear_in_fill, clearing_reg |-> (state_reg == BK_FILL), "clearing pass left the fill sweep")
    `SLED_ASSERT(a_bk_pop_idle, pop |-> ((state_reg == BK_IDLE) && !q_status.empty), "command taken while busy")
    `SLED_ASSERT_NEXT(a_bk_fetch_result, state_reg == BK_FETCH, out_valid_reg, "fetch gave no result")

endmodule

/* rtl/core/serpentine_led_framebuffer.sv */
// a paint is queued, then written to the store when the idle executor pops it; a fetch is
// queued, popped, read into the store read register, then loaded into the result register
// throughput: one paint per cycle while the queue has room and the executor is idle; each
// fetch, fill or scroll ends before the next pop; the single write port paces fill and scroll
// reset: async active low; a clearing pass blackens the store and holds in_ready low
// meanwhile; color registers reset to 0
module serpentine_led_framebuffer
    import sled_pkg::*;
#(
    parameter int MATRIX_WIDTH  = 16,
    parameter int MATRIX_HEIGHT = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    // command channel
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] kind,
    input  logic [3:0] x_coord,
    input  logic [3:0] y_coord,
    input  logic [7:0] chain_index,
    // fetch result channel
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] green_level,
    output logic [7:0] red_level,
    output logic [7:0] blue_level,
    // configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    // drawing color registers
    logic [7:0] color_red_reg;
    logic [7:0] color_green_reg;
    logic [7:0] color_blue_reg;

    pixel_t     color;
    pixel_t     out_pixel;
    q_status_t  q_status;
    bk_status_t bk_status;
    q_item_t    push_item;
    q_item_t    head_item;
    logic       push;
    logic       pop;

    // config writes go straight into the color registers, so the port never stalls
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_red_reg   <= '0;
            color_green_reg <= '0;
            color_blue_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_RED:   color_red_reg   <= cfg_data;
                CFG_GREEN: color_green_reg <= cfg_data;
                CFG_BLUE:  color_blue_reg  <= cfg_data;
                default:
                begin
                    // index beyond the register list is ignored
                end
            endcase
        end
    end

    // stored pixel order is green, red, blue as the chain expects
    assign color.green = color_green_reg;
    assign color.red   = color_red_reg;
    assign color.blue  = color_blue_reg;

    // front: takes beats while the queue has room and no clearing pass runs, drops no-op
    // commands, maps paint coordinates to a chain index and flags out-of-range fetches
    sled_front #(
        .MATRIX_WIDTH  (MATRIX_WIDTH),
        .MATRIX_HEIGHT (MATRIX_HEIGHT)
    ) u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .chain_index (chain_index),
        .q_status    (q_status),
        .bk_status   (bk_status),
        .push        (push),
        .push_item   (push_item)
    );

    // short command queue so the front keeps taking beats while a sweep
    // runs or a result waits on the output side
    sled_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_status  (q_status)
    );

    // back: owns the pixel store, runs paints, fills, scrolls and fetches,
    // and holds the result register
    sled_back #(
        .MATRIX_WIDTH  (MATRIX_WIDTH),
        .MATRIX_HEIGHT (MATRIX_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_item (head_item),
        .q_status  (q_status),
        .pop       (pop),
        .color     (color),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_pixel (out_pixel),
        .bk_status (bk_status)
    );

    assign green_level = out_pixel.green;
    assign red_level   = out_pixel.red;
    assign blue_level  = out_pixel.blue;

endmodule
